// ===== src/dsc_pkg.sv =====
// Shared types and constants of the dual stepper step controller.
// Depends on nothing; every other file but dsc_stream_if imports it.
package dsc_pkg;

  localparam int unsigned NUM_SWITCHES = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_AT_ZERO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_AT_FULL = 2'd2;

  localparam logic [19:0] DEBOUNCE_TICKS_RST = 20'd50000;
  localparam logic [15:0] PERIOD_AT_ZERO_RST = 16'd2000;
  localparam logic [15:0] PERIOD_AT_FULL_RST = 16'd260;
  localparam logic [15:0] STEP_PERIOD_RST    = 16'd260;

  localparam logic [6:0]  LEVEL_MAX = 7'd100;
  localparam logic [20:0] COUNT_MAX = 21'h1F_FFFF;
  localparam logic [15:0] SINCE_MAX = 16'hFFFF;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2^23.
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  typedef enum logic [2:0] {
    REQ_NONE      = 3'd0,
    REQ_SET_SPEED = 3'd1,
    REQ_START_FWD = 3'd2,
    REQ_START_REV = 3'd3,
    REQ_STOP      = 3'd4,
    REQ_STOP_ALL  = 3'd5
  } req_e;

  typedef struct packed {
    logic       start_sw_one;
    logic       start_sw_two;
    logic       rev_sw_one;
    logic       rev_sw_two;
    logic [2:0] req_type;
    logic       motor_sel;
    logic [6:0] speed_level;
  } in_word_t;

  typedef struct packed {
    logic step_strobe_one;
    logic step_strobe_two;
    logic enable_n_one;
    logic enable_n_two;
    logic dir_one;
    logic dir_two;
    logic cmd_error;
  } out_word_t;

  // Settled edge of one switch.
  typedef struct packed {
    logic press;
    logic release_sw;
  } switch_evt_t;

  // Decoded command for one motor.
  typedef struct packed {
    logic        stop_all;
    logic        set_speed;
    logic        start;
    logic        start_fwd;
    logic        stop;
    logic [15:0] period;
  } motor_cmd_t;

  // Motor state after the tick.
  typedef struct packed {
    logic strobe;
    logic run;
    logic dir;
  } motor_out_t;

endpackage

// ===== src/dsc_stream_if.sv =====
// Valid/ready word channel used for the input and result streams.
// Payload type is a parameter; types come from dsc_pkg.
interface dsc_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/dsc_debounce.sv =====
// Debounce counter and settled level of one active-low switch.
// Depends on dsc_pkg.
module dsc_debounce
  import dsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        raw_i,
  input  logic [19:0] ticks_i,
  output switch_evt_t evt_o
);

  logic        prev_q, prev_d;
  logic        settled_q, settled_d;
  logic [20:0] count_q, count_d;
  logic        accept;

  always_comb begin
    if (raw_i != prev_q) begin
      count_d = '0;
    end else if (count_q < COUNT_MAX) begin
      count_d = count_q + 21'd1;
    end else begin
      count_d = count_q;
    end
    prev_d           = raw_i;
    accept           = (count_d > {1'b0, ticks_i}) && (raw_i != settled_q);
    settled_d        = accept ? raw_i : settled_q;
    evt_o.press      = accept && !raw_i;
    evt_o.release_sw = accept && raw_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 1'b1;
      settled_q <= 1'b1;
      count_q   <= '0;
    end else if (en_i) begin
      prev_q    <= prev_d;
      settled_q <= settled_d;
      count_q   <= count_d;
    end
  end

endmodule

// ===== src/dsc_map.sv =====
// Two-stage map of speed level to step period: level*|diff|, then /100.
// Depends on dsc_pkg.
module dsc_map
  import dsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_b_i,
  input  logic        en_c_i,
  input  logic [6:0]  level_i,
  input  logic [15:0] p0_i,
  input  logic [15:0] pfull_i,
  output logic [15:0] period_o
);

  logic        neg;
  logic [15:0] diff_abs;
  logic [22:0] prod_d, prod_q;
  logic        neg_b_q, neg_c_q;
  logic [46:0] recip_prod;
  logic [15:0] quot_d, quot_q;

  assign neg      = pfull_i < p0_i;
  assign diff_abs = neg ? (p0_i - pfull_i) : (pfull_i - p0_i);
  assign prod_d   = 23'(level_i) * 23'(diff_abs);

  assign recip_prod = 47'(prod_q) * 47'(RECIP_100);
  // Quotient never exceeds 65535 for levels up to 100, the only ones whose period is used.
  assign quot_d     = recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      prod_q  <= prod_d;
      neg_b_q <= neg;
    end
    if (en_c_i) begin
      quot_q  <= quot_d;
      neg_c_q <= neg_b_q;
    end
  end

  // Truncation toward zero: subtract the magnitude when the slope is negative.
  assign period_o = neg_c_q ? (p0_i - quot_q) : (p0_i + quot_q);

endmodule

// ===== src/dsc_motor.sv =====
// Run, direction, period and step timer of one motor.
// Depends on dsc_pkg.
module dsc_motor
  import dsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  switch_evt_t start_evt_i,
  input  switch_evt_t rev_evt_i,
  input  motor_cmd_t  cmd_i,
  output motor_out_t  out_o
);

  logic        run_q, run_d;
  logic        dir_q, dir_d;
  logic [15:0] period_q, period_d;
  logic [15:0] since_q, since_d;
  logic [15:0] elapsed;
  logic        strobe;

  always_comb begin
    run_d    = run_q;
    dir_d    = dir_q;
    period_d = period_q;

    // Start switch, then reverse switch.
    if (start_evt_i.press && !run_d) begin
      run_d = 1'b1;
      dir_d = 1'b1;
    end else if (start_evt_i.release_sw) begin
      run_d = 1'b0;
    end
    if (rev_evt_i.press && !run_d) begin
      run_d = 1'b1;
      dir_d = 1'b0;
    end else if (rev_evt_i.release_sw) begin
      run_d = 1'b0;
    end

    // Command.
    if (cmd_i.stop_all) begin
      run_d = 1'b0;
    end else if (cmd_i.set_speed) begin
      period_d = cmd_i.period;
      if (!run_d) begin
        run_d = 1'b1;
        dir_d = 1'b1;
      end
    end else if (cmd_i.start) begin
      run_d    = 1'b1;
      dir_d    = cmd_i.start_fwd;
      period_d = cmd_i.period;
    end else if (cmd_i.stop) begin
      run_d = 1'b0;
      dir_d = 1'b1;
    end

    // Step timing; the count runs on while stopped.
    elapsed = (since_q == SINCE_MAX) ? SINCE_MAX : since_q + 16'd1;
    strobe  = run_d && (elapsed >= period_d);
    since_d = strobe ? '0 : elapsed;

    out_o.strobe = strobe;
    out_o.run    = run_d;
    out_o.dir    = dir_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      dir_q    <= 1'b1;
      period_q <= STEP_PERIOD_RST;
      since_q  <= '0;
    end else if (en_i) begin
      run_q    <= run_d;
      dir_q    <= dir_d;
      period_q <= period_d;
      since_q  <= since_d;
    end
  end

endmodule

// ===== src/dual_stepper_step_controller.sv =====
// Dual stepper step controller: four-stage pipeline, input register A, map stage B,
// commit stage C, result register; depth set by the two map multiplies, one per stage.
// One word per cycle while the result side is ready.
// Reset (async, active low) clears the pipeline, stops both motors, sets them
// forward at period 260, releases all switches and loads the register defaults.
// Depends on dsc_pkg, dsc_stream_if, dsc_debounce, dsc_map, dsc_motor.
module dual_stepper_step_controller
  import dsc_pkg::*;
#(
  parameter int unsigned NUM_MOTORS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dsc_stream_if.sink            in_i,
  dsc_stream_if.source          out_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers, written only while the pipeline is empty (user rule).
  // ---------------------------------------------------------------------------
  logic [19:0] debounce_ticks_q;
  logic [15:0] period_at_zero_q;
  logic [15:0] period_at_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DEBOUNCE_TICKS_RST;
      period_at_zero_q <= PERIOD_AT_ZERO_RST;
      period_at_full_q <= PERIOD_AT_FULL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data_i;
        CFG_PERIOD_AT_ZERO: period_at_zero_q <= cfg_data_i[15:0];
        CFG_PERIOD_AT_FULL: period_at_full_q <= cfg_data_i[15:0];
        default: ; // index beyond the register list: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage loads when it is empty or the next one moves,
  // so bubbles collapse and a stalled result only backs up as far as needed.
  // ---------------------------------------------------------------------------
  logic va_q, vb_q, vc_q, vo_q;
  logic en_a, en_b, en_c, en_o;
  logic commit;

  assign en_o   = !vo_q || out_o.ready;
  assign en_c   = !vc_q || en_o;
  assign en_b   = !vb_q || en_c;
  assign en_a   = !va_q || en_b;
  assign commit = vc_q && en_o;  // stage C word updates state and leaves

  assign in_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_i.valid;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_o) vo_q <= vc_q;
    end
  end

  in_word_t a_q, b_q, c_q;

  always_ff @(posedge clk_i) begin
    if (en_a) a_q <= in_i.data;
    if (en_b) b_q <= a_q;
    if (en_c) c_q <= b_q;
  end

  // ---------------------------------------------------------------------------
  // Speed level to period map, aligned with stage C.
  // ---------------------------------------------------------------------------
  logic [15:0] map_period;

  dsc_map u_map (
    .clk_i    (clk_i),
    .en_b_i   (en_b),
    .en_c_i   (en_c),
    .level_i  (a_q.speed_level),
    .p0_i     (period_at_zero_q),
    .pfull_i  (period_at_full_q),
    .period_o (map_period)
  );

  // ---------------------------------------------------------------------------
  // Switch debounce: index 0/1 start switches, 2/3 reverse switches.
  // ---------------------------------------------------------------------------
  logic [NUM_SWITCHES-1:0] raw_sw;
  switch_evt_t             sw_evt [NUM_SWITCHES];

  assign raw_sw = {c_q.rev_sw_two, c_q.rev_sw_one, c_q.start_sw_two, c_q.start_sw_one};

  for (genvar s = 0; s < NUM_SWITCHES; s++) begin : g_sw
    dsc_debounce u_deb (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (commit),
      .raw_i   (raw_sw[s]),
      .ticks_i (debounce_ticks_q),
      .evt_o   (sw_evt[s])
    );
  end

  // ---------------------------------------------------------------------------
  // Command decode and motor lanes.
  // ---------------------------------------------------------------------------
  req_e req;
  logic level_ok;
  logic sel_valid;
  logic cmd_err;

  assign req       = req_e'(c_q.req_type);
  assign level_ok  = c_q.speed_level <= LEVEL_MAX;
  assign sel_valid = int'(c_q.motor_sel) < NUM_MOTORS;
  assign cmd_err   = (req == REQ_SET_SPEED) && !level_ok && sel_valid;

  motor_out_t mo [NUM_MOTORS];

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_motor
    motor_cmd_t  cmd;
    switch_evt_t start_evt, rev_evt;
    logic        hit;

    assign hit = int'(c_q.motor_sel) == m;

    always_comb begin
      cmd.stop_all  = req == REQ_STOP_ALL;
      cmd.set_speed = (req == REQ_SET_SPEED) && hit && level_ok;
      cmd.start     = ((req == REQ_START_FWD) || (req == REQ_START_REV)) && hit;
      cmd.start_fwd = req == REQ_START_FWD;
      cmd.stop      = (req == REQ_STOP) && hit;
      cmd.period    = cmd.set_speed ? map_period : period_at_full_q;
    end

    // Only the first two motors have switches.
    if (m < 2) begin : g_wired
      assign start_evt = sw_evt[m];
      assign rev_evt   = sw_evt[m+2];
    end else begin : g_unwired
      assign start_evt = '0;
      assign rev_evt   = '0;
    end

    dsc_motor u_motor (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (commit),
      .start_evt_i (start_evt),
      .rev_evt_i   (rev_evt),
      .cmd_i       (cmd),
      .out_o       (mo[m])
    );
  end

  // Motor two pins idle (no strobe, disabled, forward) when there is no lane.
  motor_out_t mo_two;

  if (NUM_MOTORS > 1) begin : g_two
    assign mo_two = mo[1];
  end else begin : g_no_two
    assign mo_two = '{strobe: 1'b0, run: 1'b0, dir: 1'b1};
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  out_word_t o_d, o_q;

  always_comb begin
    o_d.step_strobe_one = mo[0].strobe;
    o_d.step_strobe_two = mo_two.strobe;
    o_d.enable_n_one    = !mo[0].run;
    o_d.enable_n_two    = !mo_two.run;
    o_d.dir_one         = mo[0].dir;
    o_d.dir_two         = mo_two.dir;
    o_d.cmd_error       = cmd_err;
  end

  always_ff @(posedge clk_i) begin
    if (commit) o_q <= o_d;
  end

  assign out_o.valid = vo_q;
  assign out_o.data  = o_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_ready_low_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !in_i.ready |-> va_q
  ) else $error("input stalled with stage A empty");

  a_commit_fills_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) commit |=> vo_q
  ) else $error("committed word did not reach the result register");

  a_strobe_one_runs: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && out_o.data.step_strobe_one |-> !out_o.data.enable_n_one
  ) else $error("step strobe on motor one while disabled");

  a_strobe_two_runs: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && out_o.data.step_strobe_two |-> !out_o.data.enable_n_two
  ) else $error("step strobe on motor two while disabled");

endmodule

// ===== test/dsc_step_checker.sv =====
// Scoreboard for the dual stepper step controller: mirrors the block per tick
// and compares every result word with its prediction. Depends on dsc_pkg.
module dsc_step_checker
  import dsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_word_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_word_t             out_data_i,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  localparam int unsigned MOTORS = 2;

  // Register copies.
  logic [19:0] deb_ticks;
  logic [15:0] per_zero;
  logic [15:0] per_full;

  // Switch and motor state.
  logic        raw_prev  [NUM_SWITCHES];
  logic        settled   [NUM_SWITCHES];
  logic [20:0] deb_cnt   [NUM_SWITCHES];
  logic        running   [MOTORS];
  logic        fwd       [MOTORS];
  logic [15:0] step_per  [MOTORS];
  logic [15:0] since_step[MOTORS];

  out_word_t due_outputs[$];
  out_word_t predicted;
  out_word_t due_word;
  int        fails;

  initial begin
    deb_ticks = DEBOUNCE_TICKS_RST;
    per_zero  = PERIOD_AT_ZERO_RST;
    per_full  = PERIOD_AT_FULL_RST;
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      raw_prev[i] = 1'b1;
      settled[i]  = 1'b1;
      deb_cnt[i]  = '0;
    end
    for (int i = 0; i < MOTORS; i++) begin
      running[i]    = 1'b0;
      fwd[i]        = 1'b1;
      step_per[i]   = STEP_PERIOD_RST;
      since_step[i] = '0;
    end
    fails      = 0;
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  task automatic debounce_switch(int sw, int m, logic raw, logic reverse);
    if (raw != raw_prev[sw]) begin
      deb_cnt[sw] = '0;
    end else if (deb_cnt[sw] != COUNT_MAX) begin
      deb_cnt[sw] = deb_cnt[sw] + 21'd1;
    end
    raw_prev[sw] = raw;
    if (deb_cnt[sw] > {1'b0, deb_ticks} && raw != settled[sw]) begin
      settled[sw] = raw;
      if (!raw) begin
        // press only starts an idle motor
        if (!running[m]) begin
          running[m] = 1'b1;
          fwd[m]     = !reverse;
        end
      end else begin
        running[m] = 1'b0;
      end
    end
  endtask

  // Linear map, quotient truncated toward zero.
  function automatic logic [15:0] level_to_period(logic [6:0] lvl);
    longint base;
    longint span;
    longint quot;
    base = longint'(per_zero);
    span = longint'(per_full) - base;
    quot = (longint'(lvl) * span) / longint'(LEVEL_MAX);
    return 16'(base + quot);
  endfunction

  task automatic advance_controller(in_word_t w, output out_word_t o);
    logic [15:0] elapsed;
    logic        strobe[MOTORS];
    logic        err;
    int          m;
    debounce_switch(0, 0, w.start_sw_one, 1'b0);
    debounce_switch(1, 1, w.start_sw_two, 1'b0);
    debounce_switch(2, 0, w.rev_sw_one,   1'b1);
    debounce_switch(3, 1, w.rev_sw_two,   1'b1);
    err = 1'b0;
    m   = int'(w.motor_sel);
    case (w.req_type)
      REQ_STOP_ALL: begin
        for (int i = 0; i < MOTORS; i++) running[i] = 1'b0;
      end
      REQ_SET_SPEED: begin
        if (w.speed_level > LEVEL_MAX) begin
          err = 1'b1;
        end else begin
          step_per[m] = level_to_period(w.speed_level);
          if (!running[m]) begin
            running[m] = 1'b1;
            fwd[m]     = 1'b1;
          end
        end
      end
      REQ_START_FWD, REQ_START_REV: begin
        running[m]  = 1'b1;
        fwd[m]      = (w.req_type == REQ_START_FWD);
        step_per[m] = per_full;
      end
      REQ_STOP: begin
        running[m] = 1'b0;
        fwd[m]     = 1'b1;
      end
      default: ;
    endcase
    // step timing runs even while stopped
    for (int i = 0; i < MOTORS; i++) begin
      elapsed = (since_step[i] != SINCE_MAX) ? since_step[i] + 16'd1 : SINCE_MAX;
      strobe[i] = running[i] && (elapsed >= step_per[i]);
      since_step[i] = strobe[i] ? 16'd0 : elapsed;
    end
    o.step_strobe_one = strobe[0];
    o.step_strobe_two = strobe[1];
    o.enable_n_one    = !running[0];
    o.enable_n_two    = !running[1];
    o.dir_one         = fwd[0];
    o.dir_two         = fwd[1];
    o.cmd_error       = err;
  endtask

  task automatic check_field(string name, logic exp_v, logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE_TICKS: deb_ticks = cfg_data_i;
          CFG_PERIOD_AT_ZERO: per_zero  = cfg_data_i[15:0];
          CFG_PERIOD_AT_FULL: per_full  = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_controller(in_data_i, predicted);
        due_outputs.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (due_outputs.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %b", $time,
                   out_data_i);
          fails++;
        end else begin
          due_word = due_outputs.pop_front();
          check_field("step_strobe_one", due_word.step_strobe_one, out_data_i.step_strobe_one);
          check_field("step_strobe_two", due_word.step_strobe_two, out_data_i.step_strobe_two);
          check_field("enable_n_one",    due_word.enable_n_one,    out_data_i.enable_n_one);
          check_field("enable_n_two",    due_word.enable_n_two,    out_data_i.enable_n_two);
          check_field("dir_one",         due_word.dir_one,         out_data_i.dir_one);
          check_field("dir_two",         due_word.dir_two,         out_data_i.dir_two);
          check_field("cmd_error",       due_word.cmd_error,       out_data_i.cmd_error);
        end
      end
      fail_cnt_o <= fails;
      pending_o  <= due_outputs.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the step controller testbench: clock, reset, stimulus and verdict.
// Depends on dsc_pkg, dsc_stream_if, dual_stepper_step_controller, dsc_step_checker.
module tb_top
  import dsc_pkg::*;
();

  // Unused command codes; the block must ignore them.
  localparam logic [2:0] REQ_RSVD_6 = 3'd6;
  localparam logic [2:0] REQ_RSVD_7 = 3'd7;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;   // receiver hold-off, well past pipeline depth
  localparam int SETTLE      = 8;     // extra slack after every word has come back

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_cnt;
  int   pending;
  int   cycle_cnt;
  bit   long_hold_req;

  // sender state
  int       burst_left;
  logic [3:0] sw_lvl;      // {start1, start2, rev1, rev2}, active low
  int       bounce_left;

  dsc_stream_if #(.word_t(in_word_t))  in_ch ();
  dsc_stream_if #(.word_t(out_word_t)) out_ch ();

  dual_stepper_step_controller #(
    .NUM_MOTORS(2)
  ) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source)
  );

  dsc_step_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_ch.valid),
    .in_ready_i (in_ch.ready),
    .in_data_i  (in_ch.data),
    .out_valid_i(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_data_i (out_ch.data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // 8-unit clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result word ends up here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Result side. Stalls follow their own run/stall pattern, with long
  // ready stretches mixed in. On request it holds ready low long enough for
  // the pipeline to back up into the input.
  initial begin
    int run_left;
    int stall_left;
    out_ch.ready = 1'b0;
    run_left     = 0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (run_left > 0) begin
        out_ch.ready <= 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          run_left   = $urandom_range(50, 200);
          stall_left = 0;
        end else begin
          run_left   = $urandom_range(0, 6);
          stall_left = $urandom_range(1, 8);
        end
      end
    end
  end

  function automatic in_word_t make_word(logic [3:0] sw, logic [2:0] req, logic sel,
                                         logic [6:0] lvl);
    in_word_t w;
    w.start_sw_one = sw[3];
    w.start_sw_two = sw[2];
    w.rev_sw_one   = sw[1];
    w.rev_sw_two   = sw[0];
    w.req_type     = req;
    w.motor_sel    = sel;
    w.speed_level  = lvl;
    return w;
  endfunction

  // Offer one word from the next falling edge; return at the edge it is taken.
  // Valid stays high so back-to-back words need no extra edge.
  task automatic send_word(in_word_t w);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop valid and wait until every word sent has come back, plus pipeline slack.
  task automatic drain;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Only called with the block drained.
  task automatic write_cfg(logic [19:0] deb, logic [15:0] p0, logic [15:0] pf);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DEBOUNCE_TICKS;
    cfg_data <= deb;
    @(negedge clk);
    cfg_idx  <= CFG_PERIOD_AT_ZERO;
    cfg_data <= CFG_DATA_W'(p0);
    @(negedge clk);
    cfg_idx  <= CFG_PERIOD_AT_FULL;
    cfg_data <= CFG_DATA_W'(pf);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Switches mostly hold their level long enough to settle, with the odd
  // bounce burst. cmd_pct sets how often a tick carries a command; low rates
  // let motors run long enough to step at long periods.
  function automatic in_word_t next_tick_word(int cmd_pct);
    int         r;
    logic [2:0] req;
    logic [6:0] lvl;
    if (bounce_left == 0 && $urandom_range(0, 39) == 0) bounce_left = $urandom_range(2, 6);
    for (int i = 0; i < 4; i++) begin
      if (bounce_left > 0) begin
        if ($urandom_range(0, 1) == 1) sw_lvl[i] = !sw_lvl[i];
      end else if ($urandom_range(0, 19) == 0) begin
        sw_lvl[i] = !sw_lvl[i];
      end
    end
    if (bounce_left > 0) bounce_left--;
    req = REQ_NONE;
    if ($urandom_range(0, 99) < cmd_pct) begin
      r = $urandom_range(0, 99);
      if (r < 30)      req = REQ_SET_SPEED;
      else if (r < 45) req = REQ_START_FWD;
      else if (r < 60) req = REQ_START_REV;
      else if (r < 75) req = REQ_STOP;
      else if (r < 85) req = REQ_STOP_ALL;
      else if (r < 93) req = REQ_RSVD_6;
      else             req = REQ_RSVD_7;
    end
    // out-of-range levels about one time in twenty: a quarter of words draw from 0..127
    lvl = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 100));
    return make_word(sw_lvl, req, 1'($urandom_range(0, 1)), lvl);
  endfunction

  // Sender bursts: random-length bursts split by random gaps, now and then a
  // long burst with no gap at all.
  task automatic run_random(int cmd_pct, int n);
    repeat (n) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
      end
      send_word(next_tick_word(cmd_pct));
      burst_left--;
    end
  endtask

  task automatic run_phase(logic [19:0] deb, logic [15:0] p0, logic [15:0] pf,
                           int cmd_pct, int n);
    drain();
    write_cfg(deb, p0, pf);
    run_random(cmd_pct, n);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_DEBOUNCE_TICKS;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = make_word(4'hF, REQ_NONE, 1'b0, 7'd0);
    long_hold_req = 1'b0;
    burst_left    = 0;
    sw_lvl        = 4'hF;
    bounce_left   = 0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // --- directed: commands at reset defaults ---
    send_word(make_word(4'hF, REQ_NONE,      1'b0, 7'd0));
    send_word(make_word(4'hF, REQ_SET_SPEED, 1'b0, 7'd0));    // slowest, idle motor starts
    send_word(make_word(4'hF, REQ_SET_SPEED, 1'b1, 7'd100));  // fastest
    send_word(make_word(4'hF, REQ_SET_SPEED, 1'b0, 7'd101));  // just over range: error
    send_word(make_word(4'hF, REQ_SET_SPEED, 1'b1, 7'd127));  // max level: error
    send_word(make_word(4'hF, REQ_START_REV, 1'b0, 7'd0));
    send_word(make_word(4'hF, REQ_START_FWD, 1'b1, 7'd0));
    send_word(make_word(4'hF, REQ_RSVD_6,    1'b0, 7'd127));  // unused codes ignored
    send_word(make_word(4'hF, REQ_RSVD_7,    1'b1, 7'd127));
    send_word(make_word(4'hF, REQ_STOP,      1'b0, 7'd0));    // stop, dir back to forward
    send_word(make_word(4'hF, REQ_STOP_ALL,  1'b0, 7'd0));    // dirs kept

    // --- directed: switches with zero debounce, period 1 ---
    drain();
    write_cfg(20'd0, 16'd1, 16'd1);
    repeat (3) send_word(make_word(4'b0111, REQ_NONE, 1'b0, 7'd0)); // start1 press
    repeat (2) send_word(make_word(4'b0101, REQ_NONE, 1'b0, 7'd0)); // rev1 while running
    repeat (2) send_word(make_word(4'b1111, REQ_NONE, 1'b0, 7'd0)); // release: stop
    repeat (2) send_word(make_word(4'b1110, REQ_NONE, 1'b0, 7'd0)); // rev2 press
    send_word(make_word(4'b1110, REQ_SET_SPEED, 1'b1, 7'd50));      // keeps reverse
    repeat (2) send_word(make_word(4'b1111, REQ_NONE, 1'b0, 7'd0));

    // --- random phases, register extremes included ---
    run_phase(20'd0,       16'd1,     16'd1,     30, 200);
    run_phase(20'hF_FFFF,  16'hFFFF,  16'hFFFF,  20, 100);
    run_phase(20'd3,       16'd20,    16'd4,     10, 250);
    run_phase(20'd0,       16'd7,     16'd30,    15, 200);
    run_phase(20'd10,      16'd1,     16'hFFFF,  25, 150);
    run_phase(20'd2,       16'hFFFF,  16'd1,     20, 150);

    // Back-pressure phase: long receiver hold-off while the sender keeps
    // offering, then a full pause until everything has come back.
    run_phase(20'd5, 16'd12, 16'd3, 5, 120);
    long_hold_req = 1'b1;
    run_random(5, 80);
    drain();
    run_random(5, 50);

    run_phase(20'($urandom_range(0, 8)), 16'($urandom_range(1, 40)),
              16'($urandom_range(1, 40)), 15, 200);

    drain();
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
